@@ rtl/frame_deserializer_crc16_x25_top_assert.svh @@
// Assertion macros for the frame deserializer top level
`ifndef FRAME_DESERIALIZER_CRC16_X25_TOP_ASSERT_SVH
`define FRAME_DESERIALIZER_CRC16_X25_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked property, disabled during reset
`define FDC_ASSERT_SEQ(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must hold at every clock edge out of reset
`define FDC_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define FDC_ASSERT_SEQ(name, prop, msg)
`define FDC_ASSERT_ALWAYS(name, expr, msg)
`endif
`endif

@@ rtl/fdc_pkg.sv @@
// Shared types, constants and CRC functions for the frame deserializer
`default_nettype none
package fdc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CRC_W       = 16;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned PUSH_W      = 2;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [COUNT_W-1:0] MIN_FRAME    = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] LEN_OVERHEAD = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] MAX_PAYLOAD  = COUNT_W'(255);

  localparam logic [COUNT_W-1:0] IDX_HEADER  = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] IDX_VERSION = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] IDX_COMMAND = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] IDX_LENGTH  = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] IDX_PAYLOAD = COUNT_W'(6);

  localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_INIT   = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_XOROUT = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXP_HEADER  = 1'b0,
    CFG_EXP_VERSION = 1'b1
  } cfg_reg_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_CRC_MISMATCH = 3'd5
  } frame_status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t          item_kind;
    logic [BYTE_W-1:0]   payload_byte;
    logic [BYTE_W-1:0]   command_code;
    frame_status_t       frame_status;
    logic                last_item;
  } res_t;

  typedef struct packed {
    logic [COUNT_W-1:0] byte_count;
  } core_stat_t;

  typedef struct packed {
    logic [FIFO_CNT_W-1:0] count;
    logic                  room2;
    logic                  not_empty;
  } fifo_stat_t;

  function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) r[i] = v[BYTE_W-1-i];
    return r;
  endfunction

  function automatic logic [CRC_W-1:0] mirror16(input logic [CRC_W-1:0] v);
    logic [CRC_W-1:0] r;
    for (int i = 0; i < CRC_W; i++) r[i] = v[CRC_W-1-i];
    return r;
  endfunction

  // Byte-wide MSB-first CRC update, input byte reflected
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] acc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] a;
    a = acc ^ {mirror8(b), BYTE_W'(0)};
    for (int i = 0; i < BYTE_W; i++) begin
      a = a[CRC_W-1] ? ({a[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {a[CRC_W-2:0], 1'b0};
    end
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fdc_in_if.sv @@
// Input byte channel: valid/ready with received byte and end-of-frame flag
`default_nettype none
interface fdc_in_if import fdc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface
`default_nettype wire

@@ rtl/fdc_out_if.sv @@
// Result channel: valid/ready with payload or frame status item
`default_nettype none
interface fdc_out_if import fdc_pkg::*;;
  logic                valid;
  logic                ready;
  logic                item_kind;
  logic [BYTE_W-1:0]   payload_byte;
  logic [BYTE_W-1:0]   command_code;
  logic [STATUS_W-1:0] frame_status;
  logic                last_item;

  modport source (output valid, output item_kind, output payload_byte,
                  output command_code, output frame_status, output last_item,
                  input ready);
  modport sink   (input valid, input item_kind, input payload_byte,
                  input command_code, input frame_status, input last_item,
                  output ready);
endinterface
`default_nettype wire

@@ rtl/frame_deserializer_crc16_x25_top.sv @@
// Top level of the CRC-16/X-25 framed packet receiver
//
//   channel  direction  transaction
//   in_ch    sink       one frame byte, frame_end on the last byte
//   out_ch   source     payload byte or end-of-frame status
//   cfg_*    write      expected header / version byte
//
// One byte is taken per cycle while the queue has room; its payload and status items are computed in
// the same cycle and land in a 4-entry result queue, whose registered entries feed out_ch. The queue
// drains one item per cycle while out_ch is ready; input stalls when fewer than two entries are free.
// A frame of N >= 6 bytes yields N-5 items.
// Reset is synchronous; no clearing pass is needed.
`default_nettype none
`include "frame_deserializer_crc16_x25_top_assert.svh"
module frame_deserializer_crc16_x25_top import fdc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  fdc_in_if.sink                      in_ch,
  fdc_out_if.source                   out_ch,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic              in_fire, out_fire;
  res_t              res_a, res_b, head;
  logic [PUSH_W-1:0] push_n;
  core_stat_t        core_stat;
  fifo_stat_t        fifo_stat;

  assign in_ch.ready = fifo_stat.room2;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  fdc_frame_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .rx_byte   (in_ch.rx_byte),
    .frame_end (in_ch.frame_end),
    .res_a     (res_a),
    .res_b     (res_b),
    .push_n    (push_n),
    .core_stat (core_stat)
  );

  fdc_out_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (push_n),
    .res_a  (res_a),
    .res_b  (res_b),
    .pop    (out_fire),
    .head   (head),
    .stat   (fifo_stat)
  );

  assign out_ch.valid        = fifo_stat.not_empty;
  assign out_ch.item_kind    = head.item_kind;
  assign out_ch.payload_byte = head.payload_byte;
  assign out_ch.command_code = head.command_code;
  assign out_ch.frame_status = head.frame_status;
  assign out_ch.last_item    = head.last_item;

  `FDC_ASSERT_ALWAYS(a_queue_bound, fifo_stat.count <= FIFO_CNT_W'(FIFO_DEPTH), "result queue overrun")
  `FDC_ASSERT_SEQ(a_frame_clear, (in_fire && in_ch.frame_end) |=> (core_stat.byte_count == '0), "frame state not cleared after status")
  `FDC_ASSERT_SEQ(a_count_adv, (in_fire && !in_ch.frame_end) |=> (core_stat.byte_count != '0), "byte count did not advance")
  `FDC_ASSERT_ALWAYS(a_last_is_status, !(out_ch.valid && out_ch.last_item) || out_ch.item_kind, "last item is not a status item")

endmodule
`default_nettype wire

@@ rtl/fdc_frame_core.sv @@
// Frame state, CRC update and per-byte result generation
`default_nettype none
module fdc_frame_core import fdc_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_fire,
  input  wire logic [BYTE_W-1:0]      rx_byte,
  input  wire logic                   frame_end,
  output res_t                        res_a,
  output res_t                        res_b,
  output logic [PUSH_W-1:0]           push_n,
  output core_stat_t                  core_stat
);

  logic [BYTE_W-1:0]  exp_hdr_r, exp_ver_r;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  logic               hdr_r, hdr_nxt, hdr_upd;
  logic               ver_r, ver_nxt, ver_upd;
  logic [BYTE_W-1:0]  cmd_r, cmd_nxt, cmd_upd;
  logic [BYTE_W-1:0]  len_r, len_nxt, len_upd;
  logic [CRC_W-1:0]   crc_r, crc_nxt, crc_upd;
  logic [BYTE_W-1:0]  dly0_r, dly0_nxt, dly1_r, dly1_nxt;
  logic [CRC_W-1:0]   crc_final, crc_given;
  logic [COUNT_W-1:0] len_ext;
  logic               emit_payload;
  frame_status_t      status;
  res_t               pay_item, stat_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_hdr_r <= '0;
      exp_ver_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_EXP_HEADER:  exp_hdr_r <= cfg_data;
        CFG_EXP_VERSION: exp_ver_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Updated frame state for the byte being taken, before end-of-frame clear
  always_comb begin
    hdr_upd = hdr_r;
    ver_upd = ver_r;
    cmd_upd = cmd_r;
    len_upd = len_r;
    if (cnt_r == IDX_HEADER)       hdr_upd = (rx_byte == exp_hdr_r);
    else if (cnt_r == IDX_VERSION) ver_upd = (rx_byte == exp_ver_r);
    else if (cnt_r == IDX_COMMAND) cmd_upd = rx_byte;
    else if (cnt_r == IDX_LENGTH)  len_upd = rx_byte;
    crc_upd = (cnt_r >= IDX_COMMAND) ? crc_fold(crc_r, dly0_r) : crc_r;
    cnt_upd = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
  end

  assign emit_payload = (cnt_r >= IDX_PAYLOAD);
  assign crc_final    = mirror16(crc_upd) ^ CRC_XOROUT;
  // CRC travels low byte first; the low byte is the earlier one, held in the newer delay slot dly1_r
  assign crc_given    = {rx_byte, dly1_r};
  assign len_ext      = {1'b0, len_upd};

  always_comb begin
    if (cnt_upd < MIN_FRAME)                                        status = ST_TOO_SHORT;
    else if (!hdr_upd)                                              status = ST_BAD_HEADER;
    else if (!ver_upd)                                              status = ST_BAD_VERSION;
    else if (len_ext > MAX_PAYLOAD || cnt_upd != len_ext + LEN_OVERHEAD)
                                                                    status = ST_LEN_MISMATCH;
    else if (crc_final != crc_given)                                status = ST_CRC_MISMATCH;
    else                                                            status = ST_OK;
  end

  always_comb begin
    pay_item              = '0;
    pay_item.item_kind    = KIND_PAYLOAD;
    pay_item.payload_byte = dly0_r;
    pay_item.frame_status = ST_OK;
    stat_item              = '0;
    stat_item.item_kind    = KIND_STATUS;
    stat_item.command_code = cmd_upd;
    stat_item.frame_status = status;
    stat_item.last_item    = 1'b1;
  end

  always_comb begin
    res_a  = emit_payload ? pay_item : stat_item;
    res_b  = stat_item;
    push_n = '0;
    if (in_fire) begin
      push_n = PUSH_W'(emit_payload) + PUSH_W'(frame_end);
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    hdr_nxt  = hdr_r;
    ver_nxt  = ver_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    crc_nxt  = crc_r;
    dly0_nxt = dly0_r;
    dly1_nxt = dly1_r;
    if (in_fire) begin
      if (frame_end) begin
        cnt_nxt  = '0;
        hdr_nxt  = 1'b0;
        ver_nxt  = 1'b0;
        cmd_nxt  = '0;
        len_nxt  = '0;
        crc_nxt  = CRC_INIT;
        dly0_nxt = '0;
        dly1_nxt = '0;
      end else begin
        cnt_nxt  = cnt_upd;
        hdr_nxt  = hdr_upd;
        ver_nxt  = ver_upd;
        cmd_nxt  = cmd_upd;
        len_nxt  = len_upd;
        crc_nxt  = crc_upd;
        dly0_nxt = dly1_r;
        dly1_nxt = rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      hdr_r  <= 1'b0;
      ver_r  <= 1'b0;
      cmd_r  <= '0;
      len_r  <= '0;
      crc_r  <= CRC_INIT;
      dly0_r <= '0;
      dly1_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      hdr_r  <= hdr_nxt;
      ver_r  <= ver_nxt;
      cmd_r  <= cmd_nxt;
      len_r  <= len_nxt;
      crc_r  <= crc_nxt;
      dly0_r <= dly0_nxt;
      dly1_r <= dly1_nxt;
    end
  end

  assign core_stat.byte_count = cnt_r;

endmodule
`default_nettype wire

@@ rtl/fdc_out_fifo.sv @@
// Result queue: takes up to two items per cycle, delivers one per cycle when popped
`default_nettype none
module fdc_out_fifo import fdc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [PUSH_W-1:0] push_n,
  input  wire res_t              res_a,
  input  wire res_t              res_b,
  input  wire logic              pop,
  output res_t                   head,
  output fifo_stat_t             stat
);

  res_t                  ent_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [FIFO_PTR_W-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + FIFO_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push_n != '0) ent_r[wr_ptr_r] <= res_a;
    if (push_n == PUSH_W'(2)) ent_r[wr_ptr_p1] <= res_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head           = ent_r[rd_ptr_r];
  assign stat.count     = count_r;
  assign stat.room2     = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign stat.not_empty = (count_r != '0);

endmodule
`default_nettype wire
